/* rtl/ctp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types, constants and fixed-point helpers for the camera target
// projection pipeline.
// ----------------------------------------------------------------------------
package ctp_pkg;

   // quotient and root widths of the iterative units
   localparam int QUO_W = 32;
   localparam int ROOT_W = 32;
   // register stages in each divider and square-root pipeline
   localparam int UNIT_LAT = QUO_W + 1;
   // numerator widths of the two divider flavours
   localparam int DIV_UV_NUM_W = 48;
   localparam int DIV_RAD_NUM_W = 63;
   // register port
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   typedef logic signed [31:0] s32_type;

   // register index, taken from paddr[5:3]
   typedef enum logic [2:0] {
      REG_MOUNT_OFFSET    = 3'd0,
      REG_ROT_ROW_X       = 3'd1,
      REG_ROT_ROW_Y       = 3'd2,
      REG_ROT_ROW_Z       = 3'd3,
      REG_TAN_HALF_FOV    = 3'd4,
      REG_FOCAL_LENGTHS   = 3'd5,
      REG_PRINCIPAL_POINT = 3'd6
   } csr_index_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [47:0] mount_offset;
      logic [47:0] rot_row_x;
      logic [47:0] rot_row_y;
      logic [47:0] rot_row_z;
      logic [63:0] tan_half_fov;
      logic [63:0] focal_lengths;
      logic [63:0] principal_point;
   } cfg_type;

   // saturate a wide signed value to 32 bits
   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      logic [31:0] res;
      if (v > 66'sd2147483647) begin
         res = 32'h7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         res = 32'h8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   // arithmetic right shift, round to nearest, ties away from zero
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                  input int unsigned sh);
      logic [63:0] half;
      logic [63:0] mag;
      logic signed [63:0] res;
      half = 64'd1 << (sh - 1);
      if (!v[63]) begin
         res = signed'((64'(v) + half) >> sh);
      end else begin
         mag = 64'(-v);
         res = -signed'((mag + half) >> sh);
      end
      return res;
   endfunction

endpackage

/* rtl/ctp_delay.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_delay
// Stalling delay line that carries a valid bit and a payload alongside the
// iterative units so that side data arrives with their results.
// ----------------------------------------------------------------------------
module ctp_delay import ctp_pkg::*; #(
   parameter int WIDTH = QUO_W,
   parameter int DEPTH = UNIT_LAT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] data_ff [DEPTH];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], in_valid};
      end
   end

   // payload chain
   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff[0] <= in_data;
         for (int k = 1; k < DEPTH; k++) begin
            data_ff[k] <= data_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

/* rtl/ctp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit the quotient width.
// ----------------------------------------------------------------------------
module ctp_div import ctp_pkg::*; #(
   parameter int NUM_W = DIV_UV_NUM_W
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num,
   input  logic [QUO_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             ovf
);

   localparam int HI_W = NUM_W - QUO_W;

   logic [QUO_W-1:0] rem_ff [QUO_W+1];
   logic [QUO_W-1:0] low_ff [QUO_W+1];
   logic [QUO_W-1:0] den_ff [QUO_W+1];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic             ovf_ff [QUO_W+1];

   logic [HI_W-1:0]  hi;
   logic             hi_ge;

   // overflow check on the upper numerator bits
   always_comb begin
      hi    = num[NUM_W-1:QUO_W];
      hi_ge = QUO_W'(hi) >= den;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ovf_ff[0] <= hi_ge;
         rem_ff[0] <= hi_ge ? '0 : QUO_W'(hi);
         low_ff[0] <= num[QUO_W-1:0];
         den_ff[0] <= den;
         quo_ff[0] <= '0;
      end
   end

   // one compare and subtract per stage
   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [QUO_W:0] sh;
      logic           ge;

      always_comb begin
         sh = {rem_ff[k-1], low_ff[k-1][QUO_W-1]};
         ge = sh >= {1'b0, den_ff[k-1]};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= ge ? QUO_W'(sh - {1'b0, den_ff[k-1]}) : sh[QUO_W-1:0];
            quo_ff[k] <= {quo_ff[k-1][QUO_W-2:0], ge};
            low_ff[k] <= low_ff[k-1] << 1;
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = quo_ff[QUO_W];
   assign ovf = ovf_ff[QUO_W];

endmodule

/* rtl/ctp_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage,
// with a final stage that saturates when the sum of squares overflowed.
// ----------------------------------------------------------------------------
module ctp_sqrt import ctp_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  logic [63:0]       radicand,
   input  logic              over,
   output logic [ROOT_W-1:0] root
);

   localparam int REM_W = ROOT_W + 2;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [63:0]       x_ff    [ROOT_W];
   logic              over_ff [ROOT_W];
   logic [ROOT_W-1:0] root_out_ff;

   // digit-by-digit stages, two radicand bits each
   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [REM_W-1:0]  rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [63:0]       x_p;
      logic              over_p;
      logic [REM_W+1:0]  rem_sh;
      logic [REM_W+1:0]  trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign x_p    = radicand;
         assign over_p = over;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign x_p    = x_ff[k-1];
         assign over_p = over_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_p, x_p[63:62]};
         trial  = {2'b00, root_p, 2'b01};
         ge     = rem_sh >= trial;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
            root_ff[k] <= {root_p[ROOT_W-2:0], ge};
            x_ff[k]    <= x_p << 2;
            over_ff[k] <= over_p;
         end
      end
   end

   // saturate on overflow
   always_ff @(posedge clock) begin
      if (adv) begin
         root_out_ff <= over_ff[ROOT_W-1] ? '1 : root_ff[ROOT_W-1];
      end
   end

   assign root = root_out_ff;

endmodule

/* rtl/ctp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_front
// Nine-stage front end: attitude matrix, camera position, body and camera
// frame rotations, and the sum of squares for the range.
// ----------------------------------------------------------------------------
module ctp_front import ctp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  cfg_type     cfg,
   input  logic        in_valid,
   input  s32_type     pursuer [3],
   input  s32_type     target [3],
   input  logic [63:0] quat,
   input  logic [30:0] radius,
   input  logic [7:0]  number,
   input  logic [31:0] ctime,
   output logic        out_valid,
   output s32_type     pc [3],
   output logic [63:0] ss,
   output logic        ss_over,
   output logic [30:0] out_radius,
   output logic [7:0]  out_number,
   output logic [31:0] out_time
);

   localparam int NSTG = 9;
   // quaternion product slots
   localparam int QP_XX = 0;
   localparam int QP_YY = 1;
   localparam int QP_ZZ = 2;
   localparam int QP_XY = 3;
   localparam int QP_XZ = 4;
   localparam int QP_YZ = 5;
   localparam int QP_WX = 6;
   localparam int QP_WY = 7;
   localparam int QP_WZ = 8;
   localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;

   typedef struct packed {
      logic [30:0] radius;
      logic [7:0]  number;
      logic [31:0] ctime;
   } side_type;

   logic [NSTG-1:0] vld_ff;
   side_type        side_ff [NSTG];

   logic signed [15:0] off [3];
   logic signed [15:0] mat [3][3];

   // stage registers
   logic signed [31:0] qp1_ff [9];
   logic [31:0]        ad1_ff [3];
   s32_type            p1_ff [3], t1_ff [3];
   logic signed [29:0] r2_ff [3][3];
   logic [63:0]        sq2_ff [3];
   s32_type            p2_ff [3], t2_ff [3];
   logic signed [45:0] po3_ff [3][3];
   logic signed [29:0] r3_ff [3][3];
   s32_type            p3_ff [3], t3_ff [3];
   logic [63:0]        ss_ff [3:NSTG];
   logic               ov_ff [3:NSTG];
   s32_type            cam4_ff [3], t4_ff [3];
   logic signed [29:0] r4_ff [3][3];
   s32_type            dw5_ff [3];
   logic signed [29:0] r5_ff [3][3];
   logic signed [61:0] pd6_ff [3][3];
   s32_type            db7_ff [3];
   logic signed [47:0] pm8_ff [3][3];
   s32_type            pc9_ff [3];

   // stage inputs
   logic signed [15:0] qw, qx, qy, qz;
   logic signed [32:0] dif [3];
   logic signed [63:0] rq [3][3];
   logic [65:0]        ss_sum;
   logic signed [63:0] acc4 [3], acc7 [3], acc9 [3];
   logic [47:0]        rows [3];

   // configuration fields
   always_comb begin
      rows[0] = cfg.rot_row_x;
      rows[1] = cfg.rot_row_y;
      rows[2] = cfg.rot_row_z;
      for (int i = 0; i < 3; i++) begin
         off[i] = signed'(cfg.mount_offset[16*i +: 16]);
         for (int j = 0; j < 3; j++) begin
            mat[i][j] = signed'(rows[i][16*j +: 16]);
         end
      end
   end

   // valid and side data chains
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{radius: radius, number: number, ctime: ctime};
         for (int k = 1; k < NSTG; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // stage 1: quaternion products and absolute position differences
   always_comb begin
      qw = signed'(quat[15:0]);
      qx = signed'(quat[31:16]);
      qy = signed'(quat[47:32]);
      qz = signed'(quat[63:48]);
      for (int i = 0; i < 3; i++) begin
         dif[i] = 33'(target[i]) - 33'(pursuer[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qp1_ff[QP_XX] <= qx * qx;
         qp1_ff[QP_YY] <= qy * qy;
         qp1_ff[QP_ZZ] <= qz * qz;
         qp1_ff[QP_XY] <= qx * qy;
         qp1_ff[QP_XZ] <= qx * qz;
         qp1_ff[QP_YZ] <= qy * qz;
         qp1_ff[QP_WX] <= qw * qx;
         qp1_ff[QP_WY] <= qw * qy;
         qp1_ff[QP_WZ] <= qw * qz;
         for (int i = 0; i < 3; i++) begin
            ad1_ff[i] <= dif[i][32] ? 32'(-dif[i]) : dif[i][31:0];
            p1_ff[i]  <= pursuer[i];
            t1_ff[i]  <= target[i];
         end
      end
   end

   // stage 2: attitude matrix in Q28, rounded to Q24; squared differences
   always_comb begin
      rq[0][0] = ONE_Q28 - ((64'(qp1_ff[QP_YY]) + 64'(qp1_ff[QP_ZZ])) <<< 1);
      rq[0][1] = (64'(qp1_ff[QP_XY]) - 64'(qp1_ff[QP_WZ])) <<< 1;
      rq[0][2] = (64'(qp1_ff[QP_XZ]) + 64'(qp1_ff[QP_WY])) <<< 1;
      rq[1][0] = (64'(qp1_ff[QP_XY]) + 64'(qp1_ff[QP_WZ])) <<< 1;
      rq[1][1] = ONE_Q28 - ((64'(qp1_ff[QP_XX]) + 64'(qp1_ff[QP_ZZ])) <<< 1);
      rq[1][2] = (64'(qp1_ff[QP_YZ]) - 64'(qp1_ff[QP_WX])) <<< 1;
      rq[2][0] = (64'(qp1_ff[QP_XZ]) - 64'(qp1_ff[QP_WY])) <<< 1;
      rq[2][1] = (64'(qp1_ff[QP_YZ]) + 64'(qp1_ff[QP_WX])) <<< 1;
      rq[2][2] = ONE_Q28 - ((64'(qp1_ff[QP_XX]) + 64'(qp1_ff[QP_YY])) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               r2_ff[i][j] <= 30'(rnd_shr(rq[i][j], 4));
            end
            sq2_ff[i] <= ad1_ff[i] * ad1_ff[i];
            p2_ff[i]  <= p1_ff[i];
            t2_ff[i]  <= t1_ff[i];
         end
      end
   end

   // stage 3: rotated mount offset products; sum of squares
   assign ss_sum = 66'(sq2_ff[0]) + 66'(sq2_ff[1]) + 66'(sq2_ff[2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               po3_ff[i][j] <= r2_ff[i][j] * off[j];
               r3_ff[i][j]  <= r2_ff[i][j];
            end
            p3_ff[i] <= p2_ff[i];
            t3_ff[i] <= t2_ff[i];
         end
         ss_ff[3] <= ss_sum[63:0];
         ov_ff[3] <= ss_sum[65:64] != 2'b00;
      end
   end

   // range sum carried to the end of the front end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 4; k <= NSTG; k++) begin
            ss_ff[k] <= ss_ff[k-1];
            ov_ff[k] <= ov_ff[k-1];
         end
      end
   end

   // stage 4: camera position
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc4[i] = 64'(po3_ff[i][0]) + 64'(po3_ff[i][1]) + 64'(po3_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            cam4_ff[i] <= sat32(66'(p3_ff[i]) + 66'(rnd_shr(acc4[i], 20)));
            t4_ff[i]   <= t3_ff[i];
            for (int j = 0; j < 3; j++) begin
               r4_ff[i][j] <= r3_ff[i][j];
            end
         end
      end
   end

   // stage 5: world delta
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dw5_ff[i] <= sat32(66'(t4_ff[i]) - 66'(cam4_ff[i]));
            for (int j = 0; j < 3; j++) begin
               r5_ff[i][j] <= r4_ff[i][j];
            end
         end
      end
   end

   // stage 6: transposed attitude products
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pd6_ff[i][j] <= r5_ff[j][i] * dw5_ff[j];
            end
         end
      end
   end

   // stage 7: body delta
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc7[i] = 64'(pd6_ff[i][0]) + 64'(pd6_ff[i][1]) + 64'(pd6_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            db7_ff[i] <= sat32(66'(rnd_shr(acc7[i], 24)));
         end
      end
   end

   // stage 8: mount matrix products
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pm8_ff[i][j] <= mat[i][j] * db7_ff[j];
            end
         end
      end
   end

   // stage 9: camera-frame vector
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc9[i] = 64'(pm8_ff[i][0]) + 64'(pm8_ff[i][1]) + 64'(pm8_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pc9_ff[i] <= sat32(66'(rnd_shr(acc9[i], 14)));
         end
      end
   end

   assign out_valid  = vld_ff[NSTG-1];
   assign pc         = pc9_ff;
   assign ss         = ss_ff[NSTG];
   assign ss_over    = ov_ff[NSTG];
   assign out_radius = side_ff[NSTG-1].radius;
   assign out_number = side_ff[NSTG-1].number;
   assign out_time   = side_ff[NSTG-1].ctime;

endmodule

/* rtl/camera_target_projection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_target_projection
// Pinhole projection of one target per transfer into a pursuer camera,
// Q16.16 fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   ports                         direction  handshake
//  request   req_*                         in         req_valid / req_stall
//  response  rsp_*                         out        rsp_valid / rsp_stall
//  config    psel penable pwrite paddr ..  in         APB, pready tied high
//
//  one transfer accepted per cycle while no held response stalls the pipeline
//  each passes 9 front stages, the 33-stage root/divider units for the
//  range and image coordinates, 2 projection stages and the 33-stage radius
//  divider, plus the output register
//  synchronous reset clears valid bits and config registers, no clearing pass
//  a held response freezes the whole pipeline, nothing lost or repeated
// ----------------------------------------------------------------------------
module camera_target_projection import ctp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [31:0]    req_pursuer_x,
   input  logic signed [31:0]    req_pursuer_y,
   input  logic signed [31:0]    req_pursuer_z,
   input  logic [63:0]           req_attitude_quat,
   input  logic signed [31:0]    req_target_x,
   input  logic signed [31:0]    req_target_y,
   input  logic signed [31:0]    req_target_z,
   input  logic [30:0]           req_target_radius,
   input  logic [7:0]            req_target_number,
   input  logic [31:0]           req_capture_time,
   // response
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_echo_target,
   output logic [31:0]           rsp_echo_time,
   output logic                  rsp_detected,
   output logic signed [31:0]    rsp_cam_fwd,
   output logic signed [31:0]    rsp_cam_right,
   output logic signed [31:0]    rsp_cam_down,
   output logic [31:0]           rsp_target_range,
   output logic signed [31:0]    rsp_norm_u,
   output logic signed [31:0]    rsp_norm_v,
   output logic signed [31:0]    rsp_pixel_u,
   output logic signed [31:0]    rsp_pixel_v,
   output logic [31:0]           rsp_radius_px,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef struct packed {
      logic [7:0]       number;
      logic [31:0]      ctime;
      logic [30:0]      radius;
      logic [2:0][31:0] pc;
      logic             fwd_ok;
      logic             neg_u;
      logic             neg_v;
   } side_a_type;

   typedef struct packed {
      logic [7:0]       number;
      logic [31:0]      ctime;
      logic             detected;
      logic [2:0][31:0] pc;
      logic [31:0]      range;
      logic [31:0]      u;
      logic [31:0]      v;
      logic [31:0]      pu;
      logic [31:0]      pv;
   } side_b_type;

   logic    adv;
   cfg_type cfg_ff;
   csr_index_type csr_idx;
   logic    csr_wr;

   // ---------------------------------------------------------------- config
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = csr_index_type'(paddr[5:3]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_MOUNT_OFFSET:    cfg_ff.mount_offset    <= pwdata[47:0];
            REG_ROT_ROW_X:       cfg_ff.rot_row_x       <= pwdata[47:0];
            REG_ROT_ROW_Y:       cfg_ff.rot_row_y       <= pwdata[47:0];
            REG_ROT_ROW_Z:       cfg_ff.rot_row_z       <= pwdata[47:0];
            REG_TAN_HALF_FOV:    cfg_ff.tan_half_fov    <= pwdata;
            REG_FOCAL_LENGTHS:   cfg_ff.focal_lengths   <= pwdata;
            REG_PRINCIPAL_POINT: cfg_ff.principal_point <= pwdata;
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_idx)
         REG_MOUNT_OFFSET:    prdata = 64'(cfg_ff.mount_offset);
         REG_ROT_ROW_X:       prdata = 64'(cfg_ff.rot_row_x);
         REG_ROT_ROW_Y:       prdata = 64'(cfg_ff.rot_row_y);
         REG_ROT_ROW_Z:       prdata = 64'(cfg_ff.rot_row_z);
         REG_TAN_HALF_FOV:    prdata = cfg_ff.tan_half_fov;
         REG_FOCAL_LENGTHS:   prdata = cfg_ff.focal_lengths;
         REG_PRINCIPAL_POINT: prdata = cfg_ff.principal_point;
         default:             prdata = '0;
      endcase
   end

   // ------------------------------------------------------------- flow ctrl
   logic rsp_valid_ff;

   // pipeline moves unless a finished response is held
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // ------------------------------------------------------------ front end
   s32_type     pur_arr [3];
   s32_type     tgt_arr [3];
   logic        f_valid;
   s32_type     f_pc [3];
   logic [63:0] f_ss;
   logic        f_over;
   logic [30:0] f_radius;
   logic [7:0]  f_number;
   logic [31:0] f_time;

   assign pur_arr = '{req_pursuer_x, req_pursuer_y, req_pursuer_z};
   assign tgt_arr = '{req_target_x, req_target_y, req_target_z};

   ctp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cfg        (cfg_ff),
      .in_valid   (req_valid),
      .pursuer    (pur_arr),
      .target     (tgt_arr),
      .quat       (req_attitude_quat),
      .radius     (req_target_radius),
      .number     (req_target_number),
      .ctime      (req_capture_time),
      .out_valid  (f_valid),
      .pc         (f_pc),
      .ss         (f_ss),
      .ss_over    (f_over),
      .out_radius (f_radius),
      .out_number (f_number),
      .out_time   (f_time)
   );

   // ------------------------------------------- range root and image ratios
   logic                    fwd_ok;
   logic [31:0]             mag_r, mag_d;
   logic [DIV_UV_NUM_W-1:0] num_u, num_v;
   logic [QUO_W-1:0]        den_f;
   side_a_type              sa_in, sa_out;
   logic                    sa_valid;
   logic [ROOT_W-1:0]       range_w;
   logic [QUO_W-1:0]        quo_u, quo_v;
   logic                    ovf_u, ovf_v;

   // magnitudes scaled by 2^16 over the forward component
   always_comb begin
      fwd_ok = !f_pc[0][31] && (f_pc[0] != '0);
      mag_r  = f_pc[1][31] ? 32'(-33'(f_pc[1])) : f_pc[1];
      mag_d  = f_pc[2][31] ? 32'(-33'(f_pc[2])) : f_pc[2];
      num_u  = {mag_r, 16'h0000};
      num_v  = {mag_d, 16'h0000};
      den_f  = fwd_ok ? f_pc[0] : QUO_W'(1);
      sa_in  = '{number: f_number, ctime: f_time, radius: f_radius,
                 pc: {f_pc[2], f_pc[1], f_pc[0]}, fwd_ok: fwd_ok,
                 neg_u: f_pc[1][31], neg_v: f_pc[2][31]};
   end

   ctp_sqrt u_sqrt (
      .clock    (clock),
      .adv      (adv),
      .radicand (f_ss),
      .over     (f_over),
      .root     (range_w)
   );

   ctp_div #(.NUM_W(DIV_UV_NUM_W)) u_div_u (
      .clock (clock),
      .adv   (adv),
      .num   (num_u),
      .den   (den_f),
      .quo   (quo_u),
      .ovf   (ovf_u)
   );

   ctp_div #(.NUM_W(DIV_UV_NUM_W)) u_div_v (
      .clock (clock),
      .adv   (adv),
      .num   (num_v),
      .den   (den_f),
      .quo   (quo_v),
      .ovf   (ovf_v)
   );

   ctp_delay #(.WIDTH($bits(side_a_type)), .DEPTH(UNIT_LAT)) u_delay_a (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_data   (sa_in),
      .out_valid (sa_valid),
      .out_data  (sa_out)
   );

   // ------------------------------------------------ field of view check
   function automatic logic [31:0] sat_mag(input logic [31:0] mag, input logic neg);
      logic [31:0] res;
      if (!neg) begin
         res = mag[31] ? 32'h7FFF_FFFF : mag;
      end else begin
         res = (mag > 32'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
      end
      return res;
   endfunction

   logic             m1_valid_ff;
   logic [7:0]       m1_number_ff;
   logic [31:0]      m1_time_ff;
   logic [30:0]      m1_radius_ff;
   logic [2:0][31:0] m1_pc_ff;
   logic [31:0]      m1_range_ff;
   logic             m1_det_ff;
   logic [31:0]      m1_u_ff, m1_v_ff;
   logic             det_w;

   assign det_w = sa_out.fwd_ok && !ovf_u && !ovf_v
                  && (quo_u <= cfg_ff.tan_half_fov[31:0])
                  && (quo_v <= cfg_ff.tan_half_fov[63:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= sa_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_number_ff <= sa_out.number;
         m1_time_ff   <= sa_out.ctime;
         m1_radius_ff <= sa_out.radius;
         m1_pc_ff     <= sa_out.pc;
         m1_range_ff  <= range_w;
         m1_det_ff    <= det_w;
         m1_u_ff      <= sat_mag(quo_u, sa_out.neg_u);
         m1_v_ff      <= sat_mag(quo_v, sa_out.neg_v);
      end
   end

   // ------------------------------------------------ pixel products
   logic               m2_valid_ff;
   logic [7:0]         m2_number_ff;
   logic [31:0]        m2_time_ff;
   logic [2:0][31:0]   m2_pc_ff;
   logic [31:0]        m2_range_ff;
   logic               m2_det_ff;
   logic [31:0]        m2_u_ff, m2_v_ff;
   logic signed [63:0] m2_pu_prod_ff, m2_pv_prod_ff;
   logic [62:0]        m2_rad_num_ff;
   logic [31:0]        m2_rad_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (adv) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_number_ff  <= m1_number_ff;
         m2_time_ff    <= m1_time_ff;
         m2_pc_ff      <= m1_pc_ff;
         m2_range_ff   <= m1_range_ff;
         m2_det_ff     <= m1_det_ff;
         m2_u_ff       <= m1_u_ff;
         m2_v_ff       <= m1_v_ff;
         m2_pu_prod_ff <= signed'({1'b0, cfg_ff.focal_lengths[31:0]})
                          * signed'(m1_u_ff);
         m2_pv_prod_ff <= signed'({1'b0, cfg_ff.focal_lengths[63:32]})
                          * signed'(m1_v_ff);
         m2_rad_num_ff <= cfg_ff.focal_lengths[31:0] * m1_radius_ff;
         m2_rad_den_ff <= (m1_range_ff == '0) ? 32'd1 : m1_range_ff;
      end
   end

   // ------------------------------------------------ radius division
   side_b_type       sb_in, sb_out;
   logic             sb_valid;
   logic [QUO_W-1:0] quo_rad;
   logic             ovf_rad;
   s32_type          cx, cy;

   // pixel coordinates, rounded and offset by the principal point
   always_comb begin
      cx    = signed'(cfg_ff.principal_point[31:0]);
      cy    = signed'(cfg_ff.principal_point[63:32]);
      sb_in = '{number: m2_number_ff, ctime: m2_time_ff, detected: m2_det_ff,
                pc: m2_pc_ff, range: m2_range_ff, u: m2_u_ff, v: m2_v_ff,
                pu: sat32(66'(rnd_shr(m2_pu_prod_ff, 16)) + 66'(cx)),
                pv: sat32(66'(rnd_shr(m2_pv_prod_ff, 16)) + 66'(cy))};
   end

   ctp_div #(.NUM_W(DIV_RAD_NUM_W)) u_div_rad (
      .clock (clock),
      .adv   (adv),
      .num   (m2_rad_num_ff),
      .den   (m2_rad_den_ff),
      .quo   (quo_rad),
      .ovf   (ovf_rad)
   );

   ctp_delay #(.WIDTH($bits(side_b_type)), .DEPTH(UNIT_LAT)) u_delay_b (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (m2_valid_ff),
      .in_data   (sb_in),
      .out_valid (sb_valid),
      .out_data  (sb_out)
   );

   // ------------------------------------------------ output register
   logic [7:0]  rsp_echo_target_ff;
   logic [31:0] rsp_echo_time_ff;
   logic        rsp_detected_ff;
   logic [31:0] rsp_cam_fwd_ff, rsp_cam_right_ff, rsp_cam_down_ff;
   logic [31:0] rsp_target_range_ff;
   logic [31:0] rsp_norm_u_ff, rsp_norm_v_ff, rsp_pixel_u_ff, rsp_pixel_v_ff;
   logic [31:0] rsp_radius_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sb_valid;
      end
   end

   // projection fields cleared when the target is not seen
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_echo_target_ff  <= sb_out.number;
         rsp_echo_time_ff    <= sb_out.ctime;
         rsp_detected_ff     <= sb_out.detected;
         rsp_cam_fwd_ff      <= sb_out.pc[0];
         rsp_cam_right_ff    <= sb_out.pc[1];
         rsp_cam_down_ff     <= sb_out.pc[2];
         rsp_target_range_ff <= sb_out.range;
         rsp_norm_u_ff       <= sb_out.detected ? sb_out.u : '0;
         rsp_norm_v_ff       <= sb_out.detected ? sb_out.v : '0;
         rsp_pixel_u_ff      <= sb_out.detected ? sb_out.pu : '0;
         rsp_pixel_v_ff      <= sb_out.detected ? sb_out.pv : '0;
         rsp_radius_px_ff    <= !sb_out.detected ? '0 : (ovf_rad ? '1 : quo_rad);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_echo_target  = rsp_echo_target_ff;
   assign rsp_echo_time    = rsp_echo_time_ff;
   assign rsp_detected     = rsp_detected_ff;
   assign rsp_cam_fwd      = rsp_cam_fwd_ff;
   assign rsp_cam_right    = rsp_cam_right_ff;
   assign rsp_cam_down     = rsp_cam_down_ff;
   assign rsp_target_range = rsp_target_range_ff;
   assign rsp_norm_u       = rsp_norm_u_ff;
   assign rsp_norm_v       = rsp_norm_v_ff;
   assign rsp_pixel_u      = rsp_pixel_u_ff;
   assign rsp_pixel_v      = rsp_pixel_v_ff;
   assign rsp_radius_px    = rsp_radius_px_ff;

`ifndef SYNTH
   // a detected target lies in front of the camera
   a_det_in_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_detected |-> rsp_cam_fwd > 32'sd0)
      else $error("detected target with non-positive forward component");

   // image fields are zero for a target that is not seen
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_detected |-> rsp_norm_u == '0 && rsp_norm_v == '0
         && rsp_pixel_u == '0 && rsp_pixel_v == '0 && rsp_radius_px == '0)
      else $error("image fields set for a target that was not seen");

   // radius divider never sees a zero divisor
   a_rad_den: assert property (@(posedge clock) disable iff (reset)
      m2_valid_ff |-> m2_rad_den_ff != '0)
      else $error("zero divisor in radius division");

   // a held response freezes the middle of the pipeline
   a_hold_mid: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(m1_valid_ff) && $stable(m2_valid_ff))
      else $error("pipeline moved while the response was held");
`endif

endmodule

/* verif/ctp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_checker
// Watches the request, response and register ports of the camera target
// projection block, predicts each result from its own copy of the registers
// and compares it field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module ctp_checker import ctp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic signed [31:0]    req_pursuer_x,
   input  logic signed [31:0]    req_pursuer_y,
   input  logic signed [31:0]    req_pursuer_z,
   input  logic [63:0]           req_attitude_quat,
   input  logic signed [31:0]    req_target_x,
   input  logic signed [31:0]    req_target_y,
   input  logic signed [31:0]    req_target_z,
   input  logic [30:0]           req_target_radius,
   input  logic [7:0]            req_target_number,
   input  logic [31:0]           req_capture_time,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [7:0]            rsp_echo_target,
   input  logic [31:0]           rsp_echo_time,
   input  logic                  rsp_detected,
   input  logic signed [31:0]    rsp_cam_fwd,
   input  logic signed [31:0]    rsp_cam_right,
   input  logic signed [31:0]    rsp_cam_down,
   input  logic [31:0]           rsp_target_range,
   input  logic signed [31:0]    rsp_norm_u,
   input  logic signed [31:0]    rsp_norm_v,
   input  logic signed [31:0]    rsp_pixel_u,
   input  logic signed [31:0]    rsp_pixel_v,
   input  logic [31:0]           rsp_radius_px,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    pending
);

   typedef struct {
      logic [7:0]  echo_target;
      logic [31:0] echo_time;
      logic        detected;
      logic [31:0] cam_fwd;
      logic [31:0] cam_right;
      logic [31:0] cam_down;
      logic [31:0] target_range;
      logic [31:0] norm_u;
      logic [31:0] norm_v;
      logic [31:0] pixel_u;
      logic [31:0] pixel_v;
      logic [31:0] radius_px;
   } projection_type;

   // shadow copy of the registers
   logic [47:0] mount_offset, row_x, row_y, row_z;
   logic [63:0] tan_half_fov, focal_lengths, principal_point;

   projection_type projections_due[$];

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // round to nearest, ties away from zero
   function automatic longint round_shift(input longint v, input int sh);
      longint unsigned half;
      longint unsigned mag;
      half = 64'd1 << (sh - 1);
      if (v >= 0) return longint'((unsigned'(v) + half) >> sh);
      mag = 64'd0 - unsigned'(v);
      return -longint'((mag + half) >> sh);
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint field16(input logic [63:0] v, input int k);
      logic [15:0] f;
      f = v[16*k +: 16];
      return longint'($signed(f));
   endfunction

   function automatic projection_type project(
      input logic signed [31:0] px, py, pz,
      input logic [63:0] quat,
      input logic signed [31:0] tx, ty, tz,
      input logic [30:0] radius,
      input logic [7:0] number,
      input logic [31:0] stamp);
      projection_type res;
      longint p[3], t[3], off[3], rot[3][3], cm[3][3], rq[3][3];
      longint campos[3], dw[3], db[3], pc[3];
      longint qw, qx, qy, qz, one, acc, d, uq, vq, u, v, fx, fy, cx, cy, pu, pv;
      longint unsigned a, rng, den, rad;
      logic [65:0] sumsq;
      logic [47:0] rows[3];
      p[0] = px; p[1] = py; p[2] = pz;
      t[0] = tx; t[1] = ty; t[2] = tz;
      qw = field16(quat, 0); qx = field16(quat, 1);
      qy = field16(quat, 2); qz = field16(quat, 3);
      rows[0] = row_x; rows[1] = row_y; rows[2] = row_z;
      for (int i = 0; i < 3; i++) begin
         off[i] = field16({16'h0, mount_offset}, i);
         for (int j = 0; j < 3; j++) cm[i][j] = field16({16'h0, rows[i]}, j);
      end
      // attitude matrix, Q28 exact then Q24
      one = 64'sd1 << 28;
      rq[0][0] = one - 2 * (qy * qy + qz * qz);
      rq[0][1] = 2 * (qx * qy - qw * qz);
      rq[0][2] = 2 * (qx * qz + qw * qy);
      rq[1][0] = 2 * (qx * qy + qw * qz);
      rq[1][1] = one - 2 * (qx * qx + qz * qz);
      rq[1][2] = 2 * (qy * qz - qw * qx);
      rq[2][0] = 2 * (qx * qz - qw * qy);
      rq[2][1] = 2 * (qy * qz + qw * qx);
      rq[2][2] = one - 2 * (qx * qx + qy * qy);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) rot[i][j] = round_shift(rq[i][j], 4);
      // camera position and world delta
      for (int i = 0; i < 3; i++) begin
         acc = rot[i][0] * off[0] + rot[i][1] * off[1] + rot[i][2] * off[2];
         campos[i] = clip32(p[i] + round_shift(acc, 20));
         dw[i] = clip32(t[i] - campos[i]);
      end
      // into body frame with the transpose, then into camera frame
      for (int i = 0; i < 3; i++) begin
         acc = rot[0][i] * dw[0] + rot[1][i] * dw[1] + rot[2][i] * dw[2];
         db[i] = clip32(round_shift(acc, 24));
      end
      for (int i = 0; i < 3; i++) begin
         acc = cm[i][0] * db[0] + cm[i][1] * db[1] + cm[i][2] * db[2];
         pc[i] = clip32(round_shift(acc, 14));
      end
      // range from the pursuer
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
         d = t[i] - p[i];
         a = (d < 0) ? unsigned'(-d) : unsigned'(d);
         sumsq = sumsq + 66'(a * a);
      end
      rng = (sumsq > 66'h0_FFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF
                                                : floor_root(sumsq[63:0]);
      if (rng > 64'hFFFF_FFFF) rng = 64'hFFFF_FFFF;

      res.echo_target = number;
      res.echo_time = stamp;
      res.detected = 1'b0;
      res.cam_fwd = pc[0][31:0];
      res.cam_right = pc[1][31:0];
      res.cam_down = pc[2][31:0];
      res.target_range = rng[31:0];
      res.norm_u = '0; res.norm_v = '0;
      res.pixel_u = '0; res.pixel_v = '0;
      res.radius_px = '0;
      if (pc[0] <= 0) return res;
      uq = (pc[1] * 65536) / pc[0];
      vq = (pc[2] * 65536) / pc[0];
      if ((uq < 0 ? -uq : uq) > longint'({32'h0, tan_half_fov[31:0]}) ||
          (vq < 0 ? -vq : vq) > longint'({32'h0, tan_half_fov[63:32]}))
         return res;
      u = clip32(uq);
      v = clip32(vq);
      fx = longint'({32'h0, focal_lengths[31:0]});
      fy = longint'({32'h0, focal_lengths[63:32]});
      cx = longint'($signed(principal_point[31:0]));
      cy = longint'($signed(principal_point[63:32]));
      pu = clip32(round_shift(fx * u, 16) + cx);
      pv = clip32(round_shift(fy * v, 16) + cy);
      den = (rng == 0) ? 64'd1 : rng;
      rad = (unsigned'(fx) * {33'h0, radius}) / den;
      if (rad > 64'hFFFF_FFFF) rad = 64'hFFFF_FFFF;
      res.detected = 1'b1;
      res.norm_u = u[31:0];
      res.norm_v = v[31:0];
      res.pixel_u = pu[31:0];
      res.pixel_v = pv[31:0];
      res.radius_px = rad[31:0];
      return res;
   endfunction

   // register writes, requests and responses
   always @(posedge clock) begin
      projection_type want;
      if (reset) begin
         mount_offset <= '0; row_x <= '0; row_y <= '0; row_z <= '0;
         tan_half_fov <= '0; focal_lengths <= '0; principal_point <= '0;
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[5:3]))
               REG_MOUNT_OFFSET:    mount_offset <= pwdata[47:0];
               REG_ROT_ROW_X:       row_x <= pwdata[47:0];
               REG_ROT_ROW_Y:       row_y <= pwdata[47:0];
               REG_ROT_ROW_Z:       row_z <= pwdata[47:0];
               REG_TAN_HALF_FOV:    tan_half_fov <= pwdata;
               REG_FOCAL_LENGTHS:   focal_lengths <= pwdata;
               REG_PRINCIPAL_POINT: principal_point <= pwdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            projections_due.push_back(project(req_pursuer_x, req_pursuer_y,
               req_pursuer_z, req_attitude_quat, req_target_x, req_target_y,
               req_target_z, req_target_radius, req_target_number,
               req_capture_time));
         if (rsp_valid && !rsp_stall) begin
            if (projections_due.size() == 0) begin
               $error("response transfer with no projection outstanding");
               fail_count++;
            end else begin
               want = projections_due.pop_front();
               if (rsp_echo_target !== want.echo_target) begin
                  $error("echo_target exp %0h got %0h", want.echo_target, rsp_echo_target);
                  fail_count++;
               end
               if (rsp_echo_time !== want.echo_time) begin
                  $error("echo_time exp %0h got %0h", want.echo_time, rsp_echo_time);
                  fail_count++;
               end
               if (rsp_detected !== want.detected) begin
                  $error("detected exp %0h got %0h", want.detected, rsp_detected);
                  fail_count++;
               end
               if (rsp_cam_fwd !== want.cam_fwd) begin
                  $error("cam_fwd exp %0h got %0h", want.cam_fwd, rsp_cam_fwd);
                  fail_count++;
               end
               if (rsp_cam_right !== want.cam_right) begin
                  $error("cam_right exp %0h got %0h", want.cam_right, rsp_cam_right);
                  fail_count++;
               end
               if (rsp_cam_down !== want.cam_down) begin
                  $error("cam_down exp %0h got %0h", want.cam_down, rsp_cam_down);
                  fail_count++;
               end
               if (rsp_target_range !== want.target_range) begin
                  $error("target_range exp %0h got %0h", want.target_range,
                         rsp_target_range);
                  fail_count++;
               end
               if (rsp_norm_u !== want.norm_u) begin
                  $error("norm_u exp %0h got %0h", want.norm_u, rsp_norm_u);
                  fail_count++;
               end
               if (rsp_norm_v !== want.norm_v) begin
                  $error("norm_v exp %0h got %0h", want.norm_v, rsp_norm_v);
                  fail_count++;
               end
               if (rsp_pixel_u !== want.pixel_u) begin
                  $error("pixel_u exp %0h got %0h", want.pixel_u, rsp_pixel_u);
                  fail_count++;
               end
               if (rsp_pixel_v !== want.pixel_v) begin
                  $error("pixel_v exp %0h got %0h", want.pixel_v, rsp_pixel_v);
                  fail_count++;
               end
               if (rsp_radius_px !== want.radius_px) begin
                  $error("radius_px exp %0h got %0h", want.radius_px, rsp_radius_px);
                  fail_count++;
               end
            end
         end
      end
      // results still owed by the block
      pending = projections_due.size();
   end

endmodule

/* verif/tb_camera_target_projection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_camera_target_projection
// Drives the projection block through several register settings with
// directed and random targets, random gaps on both channels and one long
// response hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_camera_target_projection;
   import ctp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_pursuer_x = '0, req_pursuer_y = '0, req_pursuer_z = '0;
   logic [63:0] req_attitude_quat = '0;
   logic signed [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic [30:0] req_target_radius = '0;
   logic [7:0] req_target_number = '0;
   logic [31:0] req_capture_time = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_echo_target;
   logic [31:0] rsp_echo_time;
   logic rsp_detected;
   logic signed [31:0] rsp_cam_fwd, rsp_cam_right, rsp_cam_down;
   logic [31:0] rsp_target_range;
   logic signed [31:0] rsp_norm_u, rsp_norm_v, rsp_pixel_u, rsp_pixel_v;
   logic [31:0] rsp_radius_px;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;
   int fail_count, pending;
   int cycle_count = 0;
   bit gaps_on = 1'b1;
   bit hold_request = 1'b0;

   always #5 clock = ~clock;

   camera_target_projection dut (.*);

   ctp_checker checker_i (.*);

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response side: random stalls plus one long hold-off
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_stall <= gaps_on && ($urandom_range(0, 99) < 25);
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {idx, 3'b000}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic load_settings(input logic [47:0] mnt, rx, ry, rz,
                                input logic [63:0] tanv, foc, pp);
      csr_write(REG_MOUNT_OFFSET, {16'h0, mnt});
      csr_write(REG_ROT_ROW_X, {16'h0, rx});
      csr_write(REG_ROT_ROW_Y, {16'h0, ry});
      csr_write(REG_ROT_ROW_Z, {16'h0, rz});
      csr_write(REG_TAN_HALF_FOV, tanv);
      csr_write(REG_FOCAL_LENGTHS, foc);
      csr_write(REG_PRINCIPAL_POINT, pp);
   endtask

   // one request transfer, with an optional gap before it
   task automatic send_target(input logic signed [31:0] px, py, pz,
                              input logic [63:0] quat,
                              input logic signed [31:0] tx, ty, tz,
                              input logic [30:0] radius);
      if (gaps_on && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pursuer_x <= px; req_pursuer_y <= py; req_pursuer_z <= pz;
      req_attitude_quat <= quat;
      req_target_x <= tx; req_target_y <= ty; req_target_z <= tz;
      req_target_radius <= radius;
      req_target_number <= 8'($urandom);
      req_capture_time <= $urandom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // random target, mostly ahead of a gently rotated pursuer
   task automatic random_target;
      int px, py, pz, dx, dy, dz;
      logic [63:0] quat;
      if ($urandom_range(0, 99) < 20) begin
         send_target($urandom, $urandom, $urandom, {$urandom, $urandom},
                     $urandom, $urandom, $urandom, 31'($urandom));
      end else begin
         px = int'($urandom_range(0, 1 << 24)) - (1 << 23);
         py = int'($urandom_range(0, 1 << 24)) - (1 << 23);
         pz = int'($urandom_range(0, 1 << 24)) - (1 << 23);
         dx = int'($urandom_range(1 << 16, 60 << 16));
         dy = int'($urandom_range(0, 2 * dx)) - dx;
         dz = int'($urandom_range(0, 2 * dx)) - dx;
         if ($urandom_range(0, 9) == 0) dx = -dx;
         if ($urandom_range(0, 1) == 0)
            quat = {16'h0, 16'h0, 16'h0, 16'h4000};
         else
            quat = {16'($urandom_range(0, 3000) - 1500),
                    16'($urandom_range(0, 3000) - 1500),
                    16'($urandom_range(0, 3000) - 1500), 16'd16200};
         send_target(px, py, pz, quat, px + dx, py + dy, pz + dz,
                     31'($urandom_range(0, 5 << 16)));
      end
   endtask

   localparam logic [63:0] UNIT_QUAT = {16'h0, 16'h0, 16'h0, 16'h4000};

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at reset values: nothing can be detected
      send_target(32'sh10000, 0, 0, UNIT_QUAT, 32'sh50000, 0, 0, 31'h10000);
      send_target(32'sh7FFFFFFF, 32'sh80000000, 0, {4{16'h7FFF}},
                  32'sh80000000, 32'sh7FFFFFFF, 0, 31'h7FFFFFFF);
      drain();

      // nominal camera: identity mount, 90 degree horizontal field
      load_settings({16'h0, 16'h0, 16'h0800}, {32'h0, 16'h4000},
                    {16'h0, 16'h4000, 16'h0}, {16'h4000, 32'h0},
                    {32'h0000_B000, 32'h0001_0000},
                    {32'd500 << 16, 32'd500 << 16},
                    {32'd240 << 16, 32'd320 << 16});
      // directed: in view, behind, zero range, field edges, extremes
      send_target(0, 0, 0, UNIT_QUAT, 32'sh0A0000, 0, 0, 31'h8000);
      send_target(0, 0, 0, UNIT_QUAT, -32'sh0A0000, 0, 0, 31'h8000);
      send_target(32'sh12345, 32'sh6789, 0, UNIT_QUAT,
                  32'sh12345, 32'sh6789, 0, 31'h10000);
      send_target(0, 0, 0, UNIT_QUAT, 32'sh0A0000, 32'sh0A0000, 0, 31'h10000);
      send_target(0, 0, 0, UNIT_QUAT, 32'sh0A0000, 32'sh0A0001, 0, 31'h10000);
      send_target(0, 0, 0, UNIT_QUAT, 32'sh0A0000, 0, 32'sh070000, 31'h10000);
      send_target(0, 0, 0, UNIT_QUAT, 32'sh0A0000, 0, -32'sh0A0000, 31'h10000);
      send_target(32'sh80000000, 32'sh80000000, 32'sh80000000, UNIT_QUAT,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF);
      send_target(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, UNIT_QUAT,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h0);
      send_target(0, 0, 0, {4{16'h8000}}, 32'sh0A0000, 0, 0, 31'h10000);
      send_target(0, 0, 0, {4{16'h7FFF}}, 32'sh0A0000, 0, 0, 31'h10000);
      send_target(0, 0, 0, {16'h0, 16'h0, 16'h0, 16'h2000},
                  32'sh0A0000, 32'sh10000, 0, 31'h10000);
      send_target(0, 0, 0, {16'h0, 16'h0, 16'h0, 16'hC000},
                  32'sh0A0000, 0, 0, 31'h10000);
      send_target(0, 0, 0, UNIT_QUAT, 32'sh1, 0, 0, 31'h7FFFFFFF);
      send_target(0, 0, 0, UNIT_QUAT, 32'sh9000, 32'sh7FFFFFFF, 0, 31'h10000);
      send_target(0, 0, 0, {16'h0, 16'h2D41, 16'h0, 16'h2D41},
                  32'sh0A0000, 0, 32'sh0A0000, 31'h10000);
      for (int n = 0; n < 300; n++) random_target();
      // receiver holds off while requests keep coming
      hold_request = 1'b1;
      for (int n = 0; n < 200; n++) random_target();
      // sender waits for every result, then a stretch without gaps
      drain();
      gaps_on = 1'b0;
      for (int n = 0; n < 200; n++) random_target();
      gaps_on = 1'b1;
      drain();

      // every register at all ones
      load_settings('1, '1, '1, '1, '1, '1, '1);
      for (int n = 0; n < 250; n++) random_target();
      drain();

      // random settings
      load_settings({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom});
      for (int n = 0; n < 300; n++) random_target();
      drain();

      // most negative fields, wide field of view
      load_settings({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                    {32'h7FFF_FFFF, 32'hFFFF_FFFF}, {2{32'hFFFF_FFFF}},
                    {2{32'h8000_0000}});
      for (int n = 0; n < 200; n++) random_target();
      drain();

      // camera turned about its down axis to face backward, narrow field of view
      load_settings({16'hF000, 16'h1000, 16'h8000}, {32'h0, 16'hC000},
                    {16'h0, 16'hC000, 16'h0}, {16'h4000, 32'h0},
                    {32'h0000_4000, 32'h0000_4000},
                    {32'd800 << 16, 32'd1000 << 16},
                    {32'hFFF0_0000, 32'h7FF0_0000});
      for (int n = 0; n < 300; n++) random_target();
      drain();

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
